FILE: hw/rtl/positional_list_engine_top_macros.svh
// ----------------------------------------------------------------------------
// positional_list_engine_top_macros
// Assertion macros shared by the list engine RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Property checked only while reset is low.
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types, sizes and codes shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // List capacity and the widths that follow from it
  localparam int DEPTH  = 16;
  localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response words
  localparam int OpW    = 2;
  localparam int PosW   = 5;
  localparam int ValW   = 32;
  localparam int StatW  = 2;
  localparam int EntW   = 5;

  // Common width for position / count compares
  localparam int CmpW   = (CountW > PosW) ? CountW : PosW;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell control for one cycle
  typedef struct packed {
    logic            load;
    logic            shift_up;
    logic            shift_down;
    logic [ValW-1:0] wdata;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: opcode, position and value, with valid / ready.
// ----------------------------------------------------------------------------
interface ple_req_if;
  logic                             valid;
  logic                             ready;
  ple_pkg::opcode_t                 opcode;
  logic [ple_pkg::PosW-1:0]         position;
  logic signed [ple_pkg::ValW-1:0]  item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

FILE: hw/rtl/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel: status, read value and entry count, with valid / ready.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
  logic                             valid;
  logic                             ready;
  ple_pkg::status_t                 status;
  logic signed [ple_pkg::ValW-1:0]  read_value;
  logic [ple_pkg::EntW-1:0]         entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

FILE: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: loads a new value, or takes its lower or upper neighbour's.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                      clk,
  input  ple_pkg::cell_ctl_t        ctl,
  input  logic [ple_pkg::ValW-1:0]  prev_value,
  input  logic [ple_pkg::ValW-1:0]  next_value,
  output logic [ple_pkg::ValW-1:0]  value
);

  // Load, shift towards the tail, shift towards the head, or hold
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= ctl.wdata;
    end else if (ctl.shift_up) begin
      value <= prev_value;
    end else if (ctl.shift_down) begin
      value <= next_value;
    end
  end

endmodule

FILE: hw/rtl/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed values held in a row of cells; insert, overwrite,
// delete and read by position, one response word per request word.
// ----------------------------------------------------------------------------
//  channel | dir | word contents
//  --------+-----+-------------------------------------------
//  req     | in  | opcode, position, item_value
//  rsp     | out | status, read_value, entry_count
//
// One request word per cycle while rsp drains: every cell shifts or loads
// in the same cycle, so a request completes at the edge that accepts it.
// The response sits in an output register; req is ready while that register
// is empty or being drained by rsp.ready in the same cycle.
// Synchronous reset empties the list; cell contents are not cleared.
`include "positional_list_engine_top_macros.svh"

module positional_list_engine_top (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int DEPTH  = ple_pkg::DEPTH;
  localparam int CountW = ple_pkg::CountW;
  localparam int CmpW   = ple_pkg::CmpW;
  localparam int IdxW   = ple_pkg::IdxW;
  localparam int ValW   = ple_pkg::ValW;
  localparam int EntW   = ple_pkg::EntW;

  logic [CountW-1:0]      count;
  logic [CountW-1:0]      count_next;
  logic                   req_acc;
  ple_pkg::status_t       status_next;
  logic [ValW-1:0]        rd_next;
  logic                   do_insert;
  logic                   do_write;
  logic                   do_delete;
  logic [CmpW-1:0]        pos_c;
  logic [CmpW-1:0]        cnt_c;
  logic [IdxW-1:0]        rd_idx;
  logic [ValW-1:0]        vals [DEPTH];
  ple_pkg::cell_ctl_t     ctl  [DEPTH];

  assign req.ready = !rsp.valid || rsp.ready;
  assign req_acc   = req.valid && req.ready;

  assign pos_c  = CmpW'(req.position);
  assign cnt_c  = CmpW'(count);
  assign rd_idx = IdxW'(req.position);

  // Decode the request and check position and capacity
  always_comb begin
    status_next = ple_pkg::ST_OK;
    rd_next     = '0;
    do_insert   = 1'b0;
    do_write    = 1'b0;
    do_delete   = 1'b0;
    count_next  = count;
    unique case (req.opcode)
      ple_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) begin
          status_next = ple_pkg::ST_RANGE;
        end else if (count >= CountW'(DEPTH)) begin
          status_next = ple_pkg::ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = CountW'(count + 1'b1);
        end
      end
      ple_pkg::OP_WRITE: begin
        if (pos_c >= cnt_c) begin
          status_next = ple_pkg::ST_RANGE;
        end else begin
          do_write = 1'b1;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (pos_c >= cnt_c) begin
          status_next = ple_pkg::ST_RANGE;
        end else begin
          do_delete  = 1'b1;
          rd_next    = vals[rd_idx];
          count_next = CountW'(count - 1'b1);
        end
      end
      ple_pkg::OP_READ: begin
        if (pos_c >= cnt_c) begin
          status_next = ple_pkg::ST_RANGE;
        end else begin
          rd_next = vals[rd_idx];
        end
      end
      default: begin
        status_next = ple_pkg::ST_RANGE;
      end
    endcase
  end

  // Row of cells: each slot sees its neighbours every cycle
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValW-1:0] prev_v;
    logic [ValW-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = req.item_value;
    end else begin : g_mid_lo
      assign prev_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_v = vals[i];
    end else begin : g_mid_hi
      assign next_v = vals[i+1];
    end

    // Position slot loads the new word; later slots shift, it too on delete
    always_comb begin
      ctl[i].wdata      = req.item_value;
      ctl[i].load       = req_acc && (do_insert || do_write) && (pos_c == CmpW'(i));
      ctl[i].shift_up   = req_acc && do_insert && (CmpW'(i) > pos_c);
      ctl[i].shift_down = req_acc && do_delete && (CmpW'(i) >= pos_c);
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (vals[i])
    );
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_acc) begin
      count <= count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      rsp.status      <= status_next;
      rsp.read_value  <= rd_next;
      rsp.entry_count <= EntW'(count_next);
    end
  end

  `PLE_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0), "list not empty after reset")
  `PLE_ASSERT(a_count_bound, count <= CountW'(DEPTH), "entry count above capacity")
  `PLE_ASSERT(a_insert_grows, (req_acc && req.opcode == ple_pkg::OP_INSERT && status_next == ple_pkg::ST_OK) |=> (count == CountW'($past(count) + 1'b1)), "successful insert did not grow the list")
  `PLE_ASSERT(a_full_status, (rsp.valid && rsp.status == ple_pkg::ST_FULL) |-> (count == CountW'(DEPTH)), "full status with spare capacity")
  `PLE_ASSERT(a_rsp_count, rsp.valid |-> (rsp.entry_count == EntW'(count)), "reported count differs from held count")

endmodule
